// ===== rtl/dmpr_pkg.sv =====
// Shared types, codes and constants for the dual motor PWM ramp unit.
`timescale 1ns / 1ps

package dmpr_pkg;

    // Field widths
    localparam int PERIOD_W  = 16;
    localparam int STEP_W    = 8;
    localparam int DUTY_W    = 7;
    localparam int PINS_W    = 4;
    localparam int SCALED_W  = 23;   // period * duty + half, at most 6553550
    localparam int CFG_IDX_W = 2;

    // Opcodes
    localparam logic [2:0] OP_TICK        = 3'd0;
    localparam logic [2:0] OP_SET_MOTOR   = 3'd1;
    localparam logic [2:0] OP_PIVOT_RIGHT = 3'd2;
    localparam logic [2:0] OP_PIVOT_LEFT  = 3'd3;
    localparam logic [2:0] OP_STOP        = 3'd4;
    localparam logic [2:0] OP_ARM_NOTICE  = 3'd5;

    // Motor select codes
    localparam logic [1:0] SEL_LEFT  = 2'd0;
    localparam logic [1:0] SEL_RIGHT = 2'd1;
    localparam logic [1:0] SEL_BOTH  = 2'd2;

    // Direction codes
    localparam logic [1:0] DIR_FWD  = 2'd0;
    localparam logic [1:0] DIR_BACK = 2'd1;
    localparam logic [1:0] DIR_NONE = 2'd2;

    // Direction pin patterns
    localparam logic [PINS_W-1:0] PIN_LEFT_FWD   = 4'h1;
    localparam logic [PINS_W-1:0] PIN_LEFT_BACK  = 4'h2;
    localparam logic [PINS_W-1:0] PIN_RIGHT_FWD  = 4'h4;
    localparam logic [PINS_W-1:0] PIN_RIGHT_BACK = 4'h8;
    localparam logic [PINS_W-1:0] PINS_LEFT_MASK  = 4'h3;
    localparam logic [PINS_W-1:0] PINS_RIGHT_MASK = 4'hC;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECEL  = 2'd2;

    // Configuration reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd3200;
    localparam logic [STEP_W-1:0]   ACCEL_RESET  = 8'd25;
    localparam logic [STEP_W-1:0]   DECEL_RESET  = 8'd50;

    // Percent scaling: full scale and rounding offset
    localparam logic [DUTY_W-1:0] PCT_FULL = 7'd100;
    localparam logic [DUTY_W-1:0] PCT_HALF = 7'd50;

    // Divide by 100 as multiply by ceil(2^30 / 100) and shift; exact for
    // every dividend below 2^23 since the rounding error is 76 / 2^30.
    localparam int               RECIP_SHIFT = 30;
    localparam int               RECIP_W     = 24;
    localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;
    localparam int               PROD_W      = SCALED_W + RECIP_W;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [STEP_W-1:0]   accel_step;
        logic [STEP_W-1:0]   decel_step;
    } cfg_t;

    typedef struct packed {
        logic [2:0]          op;
        logic [1:0]          motor_sel;
        logic [1:0]          direction;
        logic                immediate;
        logic [SCALED_W-1:0] scaled;
    } item_t;

endpackage

// ===== rtl/dmpr_in_stage.sv =====
// Input register: captures one command beat and the scaled duty product.
`timescale 1ns / 1ps

module dmpr_in_stage
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0]                    op,
    input  logic [1:0]                    motor_sel,
    input  logic [dmpr_pkg::DUTY_W-1:0]   duty_percent,
    input  logic [1:0]                    direction,
    input  logic                          immediate,
    input  logic [dmpr_pkg::PERIOD_W-1:0] period,
    input  logic                          advance,
    output logic                          item_valid,
    output dmpr_pkg::item_t               item
);

    logic                              valid_reg;
    logic                              valid_next;
    dmpr_pkg::item_t                   item_reg;
    dmpr_pkg::item_t                   item_next;
    logic [dmpr_pkg::DUTY_W-1:0]       duty_clamped;
    logic                              load;

    // Take a beat when empty or when the held one moves on this cycle
    assign in_ready = !valid_reg || advance;
    assign load     = in_valid && in_ready;

    // Clamp duty to full scale
    assign duty_clamped = (duty_percent > dmpr_pkg::PCT_FULL) ? dmpr_pkg::PCT_FULL
                                                               : duty_percent;

    // Form the item with period * duty + half ahead of the divide
    always_comb
    begin
        item_next.op        = op;
        item_next.motor_sel = motor_sel;
        item_next.direction = direction;
        item_next.immediate = immediate;
        item_next.scaled    = dmpr_pkg::SCALED_W'(period * duty_clamped)
                            + dmpr_pkg::SCALED_W'(dmpr_pkg::PCT_HALF);
    end

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold payload until the next beat is taken
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/dmpr_ramp.sv =====
// One ramp step: move a compare value toward its target, snapping on overshoot.
`timescale 1ns / 1ps

module dmpr_ramp
(
    input  logic [dmpr_pkg::PERIOD_W-1:0] now_val,
    input  logic [dmpr_pkg::PERIOD_W-1:0] target,
    input  dmpr_pkg::cfg_t                cfg,
    output logic [dmpr_pkg::PERIOD_W-1:0] next_val
);

    logic [dmpr_pkg::PERIOD_W:0]   up_sum;
    logic [dmpr_pkg::PERIOD_W-1:0] down_diff;
    logic [dmpr_pkg::PERIOD_W-1:0] decel_ext;

    assign up_sum    = {1'b0, now_val} + {{(dmpr_pkg::PERIOD_W+1-dmpr_pkg::STEP_W){1'b0}},
                                          cfg.accel_step};
    assign decel_ext = {{(dmpr_pkg::PERIOD_W-dmpr_pkg::STEP_W){1'b0}}, cfg.decel_step};
    assign down_diff = now_val - decel_ext;

    always_comb
    begin
        if (now_val < target)
        begin
            // Accelerate; land on target when reaching it or passing the period
            if (up_sum >= {1'b0, target} || up_sum > {1'b0, cfg.period})
            begin
                next_val = target;
            end
            else
            begin
                next_val = up_sum[dmpr_pkg::PERIOD_W-1:0];
            end
        end
        else if (now_val > target)
        begin
            // Decelerate; land on target on underflow, overshoot or above period
            if (now_val < decel_ext || down_diff <= target || down_diff > cfg.period)
            begin
                next_val = target;
            end
            else
            begin
                next_val = down_diff;
            end
        end
        else
        begin
            next_val = now_val;
        end
    end

endmodule

// ===== rtl/dmpr_core.sv =====
// Command decode, motor state and result registers.
`timescale 1ns / 1ps

module dmpr_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  dmpr_pkg::item_t               item,
    input  dmpr_pkg::cfg_t                cfg,
    output logic [dmpr_pkg::PERIOD_W-1:0] left_now,
    output logic [dmpr_pkg::PERIOD_W-1:0] right_now,
    output logic [dmpr_pkg::PINS_W-1:0]   pins,
    output logic                          stopped
);

    logic [dmpr_pkg::PERIOD_W-1:0] left_now_reg;
    logic [dmpr_pkg::PERIOD_W-1:0] left_now_next;
    logic [dmpr_pkg::PERIOD_W-1:0] right_now_reg;
    logic [dmpr_pkg::PERIOD_W-1:0] right_now_next;
    logic [dmpr_pkg::PERIOD_W-1:0] left_target_reg;
    logic [dmpr_pkg::PERIOD_W-1:0] left_target_next;
    logic [dmpr_pkg::PERIOD_W-1:0] right_target_reg;
    logic [dmpr_pkg::PERIOD_W-1:0] right_target_next;
    logic [dmpr_pkg::PINS_W-1:0]   pins_reg;
    logic [dmpr_pkg::PINS_W-1:0]   pins_next;
    logic                          armed_reg;
    logic                          armed_next;
    logic                          stopped_reg;
    logic                          stopped_next;
    logic [dmpr_pkg::PROD_W-1:0]   quot_prod;
    logic [dmpr_pkg::PERIOD_W-1:0] setpoint;
    logic [dmpr_pkg::PERIOD_W-1:0] left_ramp;
    logic [dmpr_pkg::PERIOD_W-1:0] right_ramp;

    // Divide the scaled duty by 100 through the reciprocal
    assign quot_prod = dmpr_pkg::PROD_W'(item.scaled) * dmpr_pkg::PROD_W'(dmpr_pkg::RECIP_100);
    assign setpoint  = quot_prod[dmpr_pkg::RECIP_SHIFT +: dmpr_pkg::PERIOD_W];

    dmpr_ramp u_left_ramp
    (
        .now_val  (left_now_reg),
        .target   (left_target_reg),
        .cfg      (cfg),
        .next_val (left_ramp)
    );

    dmpr_ramp u_right_ramp
    (
        .now_val  (right_now_reg),
        .target   (right_target_reg),
        .cfg      (cfg),
        .next_val (right_ramp)
    );

    // Apply one command or tick to the motor state
    always_comb
    begin
        left_now_next     = left_now_reg;
        right_now_next    = right_now_reg;
        left_target_next  = left_target_reg;
        right_target_next = right_target_reg;
        pins_next         = pins_reg;
        armed_next        = armed_reg;
        stopped_next      = 1'b0;

        case (item.op)
            dmpr_pkg::OP_TICK:
            begin
                left_now_next  = left_ramp;
                right_now_next = right_ramp;
                if (armed_reg && left_ramp == '0 && right_ramp == '0)
                begin
                    stopped_next = 1'b1;
                    armed_next   = 1'b0;
                end
            end

            dmpr_pkg::OP_SET_MOTOR:
            begin
                case (item.motor_sel)
                    dmpr_pkg::SEL_LEFT:
                    begin
                        case (item.direction)
                            dmpr_pkg::DIR_FWD:
                            begin
                                pins_next = (pins_reg & dmpr_pkg::PINS_RIGHT_MASK)
                                          | dmpr_pkg::PIN_LEFT_FWD;
                                left_target_next = setpoint;
                            end
                            dmpr_pkg::DIR_BACK:
                            begin
                                pins_next = (pins_reg & dmpr_pkg::PINS_RIGHT_MASK)
                                          | dmpr_pkg::PIN_LEFT_BACK;
                                left_target_next = setpoint;
                            end
                            dmpr_pkg::DIR_NONE:
                            begin
                                pins_next = pins_reg & dmpr_pkg::PINS_RIGHT_MASK;
                            end
                            default:
                            begin
                                left_target_next = '0;
                            end
                        endcase
                        if (item.immediate)
                        begin
                            left_now_next = left_target_next;
                        end
                    end

                    dmpr_pkg::SEL_RIGHT:
                    begin
                        case (item.direction)
                            dmpr_pkg::DIR_FWD:
                            begin
                                pins_next = (pins_reg & dmpr_pkg::PINS_LEFT_MASK)
                                          | dmpr_pkg::PIN_RIGHT_FWD;
                                right_target_next = setpoint;
                            end
                            dmpr_pkg::DIR_BACK:
                            begin
                                pins_next = (pins_reg & dmpr_pkg::PINS_LEFT_MASK)
                                          | dmpr_pkg::PIN_RIGHT_BACK;
                                right_target_next = setpoint;
                            end
                            dmpr_pkg::DIR_NONE:
                            begin
                                pins_next = pins_reg & dmpr_pkg::PINS_LEFT_MASK;
                            end
                            default:
                            begin
                                right_target_next = '0;
                            end
                        endcase
                        if (item.immediate)
                        begin
                            right_now_next = right_target_next;
                        end
                    end

                    dmpr_pkg::SEL_BOTH:
                    begin
                        case (item.direction)
                            dmpr_pkg::DIR_FWD:
                            begin
                                pins_next = dmpr_pkg::PIN_LEFT_FWD | dmpr_pkg::PIN_RIGHT_FWD;
                                left_target_next  = setpoint;
                                right_target_next = setpoint;
                            end
                            dmpr_pkg::DIR_BACK:
                            begin
                                pins_next = dmpr_pkg::PIN_LEFT_BACK | dmpr_pkg::PIN_RIGHT_BACK;
                                left_target_next  = setpoint;
                                right_target_next = setpoint;
                            end
                            default:
                            begin
                                // None or invalid: drop both targets, keep pins
                                left_target_next  = '0;
                                right_target_next = '0;
                            end
                        endcase
                        if (item.immediate)
                        begin
                            left_now_next  = left_target_next;
                            right_now_next = right_target_next;
                        end
                    end

                    default:
                    begin
                        // No motor addressed: leave state alone
                    end
                endcase
            end

            dmpr_pkg::OP_PIVOT_RIGHT, dmpr_pkg::OP_PIVOT_LEFT:
            begin
                if (item.op == dmpr_pkg::OP_PIVOT_RIGHT)
                begin
                    pins_next = dmpr_pkg::PIN_LEFT_FWD | dmpr_pkg::PIN_RIGHT_BACK;
                end
                else
                begin
                    pins_next = dmpr_pkg::PIN_LEFT_BACK | dmpr_pkg::PIN_RIGHT_FWD;
                end
                left_target_next  = setpoint;
                right_target_next = setpoint;
                if (item.immediate)
                begin
                    left_now_next  = setpoint;
                    right_now_next = setpoint;
                end
            end

            dmpr_pkg::OP_STOP:
            begin
                left_target_next  = '0;
                right_target_next = '0;
            end

            dmpr_pkg::OP_ARM_NOTICE:
            begin
                armed_next = 1'b1;
            end

            default:
            begin
                // Unused opcode: result only
            end
        endcase
    end

    // Advance state only when the result moves into the output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_now_reg     <= '0;
            right_now_reg    <= '0;
            left_target_reg  <= '0;
            right_target_reg <= '0;
            pins_reg         <= '0;
            armed_reg        <= 1'b0;
            stopped_reg      <= 1'b0;
        end
        else if (advance)
        begin
            left_now_reg     <= left_now_next;
            right_now_reg    <= right_now_next;
            left_target_reg  <= left_target_next;
            right_target_reg <= right_target_next;
            pins_reg         <= pins_next;
            armed_reg        <= armed_next;
            stopped_reg      <= stopped_next;
        end
    end

    assign left_now  = left_now_reg;
    assign right_now = right_now_reg;
    assign pins      = pins_reg;
    assign stopped   = stopped_reg;

endmodule

// ===== rtl/dual_motor_pwm_ramp_unit.sv =====
// Top level of the two-motor PWM drive with slew-limited compare values.
`timescale 1ns / 1ps

// Accepts one command or ramp tick per clock and returns one result beat per
// item: the compare values, direction pins and the one-shot stopped flag as
// they stand after the item. Period * duty is formed as the item enters the
// input register; when the item moves on, the divide by 100 and the state
// update are worked out from that register and land in the motor state
// registers that also serve as the output register. Throughput is one item
// per cycle while the output is taken; a stalled output holds the pipeline
// and drops in_ready once both stages are full. Configuration writes take
// effect on the next edge and are meant for an idle unit.

module dual_motor_pwm_ramp_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [dmpr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dmpr_pkg::PERIOD_W-1:0]  cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [2:0]                     op,
    input  logic [1:0]                     motor_sel,
    input  logic [dmpr_pkg::DUTY_W-1:0]    duty_percent,
    input  logic [1:0]                     direction,
    input  logic                           immediate,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [dmpr_pkg::PERIOD_W-1:0]  left_compare,
    output logic [dmpr_pkg::PERIOD_W-1:0]  right_compare,
    output logic [dmpr_pkg::PINS_W-1:0]    direction_pins,
    output logic                           stopped
);

    dmpr_pkg::cfg_t  cfg_reg;
    dmpr_pkg::cfg_t  cfg_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            item_valid;
    dmpr_pkg::item_t item;
    logic            advance;

    // Register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                dmpr_pkg::CFG_PERIOD: cfg_next.period     = cfg_data;
                dmpr_pkg::CFG_ACCEL:  cfg_next.accel_step = cfg_data[dmpr_pkg::STEP_W-1:0];
                dmpr_pkg::CFG_DECEL:  cfg_next.decel_step = cfg_data[dmpr_pkg::STEP_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period     <= dmpr_pkg::PERIOD_RESET;
            cfg_reg.accel_step <= dmpr_pkg::ACCEL_RESET;
            cfg_reg.decel_step <= dmpr_pkg::DECEL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Move the held item on when the output stage is free or being drained
    assign advance = item_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    dmpr_in_stage u_in_stage
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .motor_sel    (motor_sel),
        .duty_percent (duty_percent),
        .direction    (direction),
        .immediate    (immediate),
        .period       (cfg_reg.period),
        .advance      (advance),
        .item_valid   (item_valid),
        .item         (item)
    );

    dmpr_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (item),
        .cfg       (cfg_reg),
        .left_now  (left_compare),
        .right_now (right_compare),
        .pins      (direction_pins),
        .stopped   (stopped)
    );

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/dmpr_checker.sv =====
// Port-level checks for the dual motor PWM ramp unit, bound to the top level.
`timescale 1ns / 1ps

module dmpr_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [dmpr_pkg::PERIOD_W-1:0]  left_compare,
    input logic [dmpr_pkg::PERIOD_W-1:0]  right_compare,
    input logic [dmpr_pkg::PINS_W-1:0]    direction_pins,
    input logic                           stopped
);

    // A stalled result beat holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(left_compare)
            && $stable(right_compare) && $stable(direction_pins) && $stable(stopped))
    else $error("result beat changed while stalled");

    // Stopped only reports with both motors at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stopped |-> left_compare == '0 && right_compare == '0)
    else $error("stopped flagged with a nonzero compare value");

    // Never drive one motor forward and backward at once
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(direction_pins[0] && direction_pins[1])
            && !(direction_pins[2] && direction_pins[3]))
    else $error("conflicting direction pins on one motor");

    // Input backs up only behind a stalled output
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output stage could drain");

endmodule

bind dual_motor_pwm_ramp_unit dmpr_checker u_dmpr_checker (.*);

// ===== test/testbench.sv =====
// Self-checking testbench for the dual motor PWM ramp unit.
`timescale 1ns / 1ps

module testbench;

    import dmpr_pkg::*;

    // Codes with no name in the package
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;
    localparam logic [1:0] SEL_SPARE  = 2'd3;
    localparam logic [1:0] DIR_BAD    = 2'd3;

    localparam int QUIET_LIMIT = 1000;  // cycles with no beat on either side
    localparam int DRAIN_SLACK = 3;     // extra edges after the last expected beat is back

    typedef struct packed {
        logic [2:0]        op;
        logic [1:0]        sel;
        logic [DUTY_W-1:0] duty;
        logic [1:0]        dir;
        logic              imm;
    } motor_cmd_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] left_cmp;
        logic [PERIOD_W-1:0] right_cmp;
        logic [PINS_W-1:0]   pins;
        logic                stopped;
    } drive_out_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [PERIOD_W-1:0]   cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [2:0]            op;
    logic [1:0]            motor_sel;
    logic [DUTY_W-1:0]     duty_percent;
    logic [1:0]            direction;
    logic                  immediate;
    logic                  out_valid;
    logic                  out_ready;
    logic [PERIOD_W-1:0]   left_compare;
    logic [PERIOD_W-1:0]   right_compare;
    logic [PINS_W-1:0]     direction_pins;
    logic                  stopped;

    // Drive state as the unit should hold it
    logic [PERIOD_W-1:0] left_cmp_q    = '0;
    logic [PERIOD_W-1:0] right_cmp_q   = '0;
    logic [PERIOD_W-1:0] left_goal_q   = '0;
    logic [PERIOD_W-1:0] right_goal_q  = '0;
    logic [PINS_W-1:0]   pins_q        = '0;
    logic                notice_armed_q = 1'b0;
    logic [PERIOD_W-1:0] period_q      = PERIOD_RESET;
    logic [STEP_W-1:0]   accel_q       = ACCEL_RESET;
    logic [STEP_W-1:0]   decel_q       = DECEL_RESET;

    drive_out_t pending_drive_q[$];
    int         mismatch_count = 0;
    int         quiet_cycles   = 0;
    int         sink_hold      = 0;
    bit         idle_en        = 1'b1;

    dual_motor_pwm_ramp_unit dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .motor_sel      (motor_sel),
        .duty_percent   (duty_percent),
        .direction      (direction),
        .immediate      (immediate),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .left_compare   (left_compare),
        .right_compare  (right_compare),
        .direction_pins (direction_pins),
        .stopped        (stopped)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Percent to compare value, rounded, duty clamped at full scale
    function automatic logic [PERIOD_W-1:0] duty_to_goal(input logic [DUTY_W-1:0] duty);
        int unsigned pct;
        pct = (duty > PCT_FULL) ? PCT_FULL : duty;
        return PERIOD_W'((period_q * pct + PCT_HALF) / PCT_FULL);
    endfunction

    // One slew step; land on the goal on overshoot, underflow or passing period
    function automatic logic [PERIOD_W-1:0] slew_toward(input logic [PERIOD_W-1:0] now,
                                                        input logic [PERIOD_W-1:0] goal);
        int unsigned sum;
        int unsigned diff;
        if (now < goal)
        begin
            sum = now + accel_q;
            return (sum >= goal || sum > period_q) ? goal : PERIOD_W'(sum);
        end
        if (now > goal)
        begin
            if (now < decel_q)
                return goal;
            diff = now - decel_q;
            return (diff <= goal || diff > period_q) ? goal : PERIOD_W'(diff);
        end
        return now;
    endfunction

    // Apply one command or tick to the drive state and return the result beat
    function automatic drive_out_t advance_drive(input motor_cmd_t c);
        drive_out_t          r;
        logic [PERIOD_W-1:0] goal;
        goal      = duty_to_goal(c.duty);
        r.stopped = 1'b0;
        case (c.op)
            OP_TICK:
            begin
                left_cmp_q  = slew_toward(left_cmp_q, left_goal_q);
                right_cmp_q = slew_toward(right_cmp_q, right_goal_q);
                if (notice_armed_q && left_cmp_q == '0 && right_cmp_q == '0)
                begin
                    r.stopped      = 1'b1;
                    notice_armed_q = 1'b0;
                end
            end
            OP_SET_MOTOR:
            begin
                case (c.sel)
                    SEL_LEFT:
                    begin
                        case (c.dir)
                            DIR_FWD:
                            begin
                                pins_q      = (pins_q & PINS_RIGHT_MASK) | PIN_LEFT_FWD;
                                left_goal_q = goal;
                            end
                            DIR_BACK:
                            begin
                                pins_q      = (pins_q & PINS_RIGHT_MASK) | PIN_LEFT_BACK;
                                left_goal_q = goal;
                            end
                            DIR_NONE: pins_q = pins_q & PINS_RIGHT_MASK;
                            default:  left_goal_q = '0;
                        endcase
                        if (c.imm)
                            left_cmp_q = left_goal_q;
                    end
                    SEL_RIGHT:
                    begin
                        case (c.dir)
                            DIR_FWD:
                            begin
                                pins_q       = (pins_q & PINS_LEFT_MASK) | PIN_RIGHT_FWD;
                                right_goal_q = goal;
                            end
                            DIR_BACK:
                            begin
                                pins_q       = (pins_q & PINS_LEFT_MASK) | PIN_RIGHT_BACK;
                                right_goal_q = goal;
                            end
                            DIR_NONE: pins_q = pins_q & PINS_LEFT_MASK;
                            default:  right_goal_q = '0;
                        endcase
                        if (c.imm)
                            right_cmp_q = right_goal_q;
                    end
                    SEL_BOTH:
                    begin
                        // none and invalid both drop the goals, pins stay
                        if (c.dir == DIR_FWD || c.dir == DIR_BACK)
                        begin
                            pins_q = (c.dir == DIR_FWD) ? (PIN_LEFT_FWD | PIN_RIGHT_FWD)
                                                        : (PIN_LEFT_BACK | PIN_RIGHT_BACK);
                            left_goal_q  = goal;
                            right_goal_q = goal;
                        end
                        else
                        begin
                            left_goal_q  = '0;
                            right_goal_q = '0;
                        end
                        if (c.imm)
                        begin
                            left_cmp_q  = left_goal_q;
                            right_cmp_q = right_goal_q;
                        end
                    end
                    default: ;
                endcase
            end
            OP_PIVOT_RIGHT, OP_PIVOT_LEFT:
            begin
                pins_q = (c.op == OP_PIVOT_RIGHT) ? (PIN_LEFT_FWD | PIN_RIGHT_BACK)
                                                  : (PIN_LEFT_BACK | PIN_RIGHT_FWD);
                left_goal_q  = goal;
                right_goal_q = goal;
                if (c.imm)
                begin
                    left_cmp_q  = goal;
                    right_cmp_q = goal;
                end
            end
            OP_STOP:
            begin
                left_goal_q  = '0;
                right_goal_q = '0;
            end
            OP_ARM_NOTICE: notice_armed_q = 1'b1;
            default: ;
        endcase
        r.left_cmp  = left_cmp_q;
        r.right_cmp = right_cmp_q;
        r.pins      = pins_q;
        return r;
    endfunction

    // Check result beats, track register writes, predict accepted commands
    always @(posedge clk)
    begin : beat_monitor
        drive_out_t got;
        drive_out_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = '{left_compare, right_compare, direction_pins, stopped};
                if (pending_drive_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result beat: L=%0d R=%0d pins=%h stopped=%0d",
                                 got.left_cmp, got.right_cmp, got.pins, got.stopped);
                end
                else
                begin
                    want = pending_drive_q.pop_front();
                    if (got.left_cmp !== want.left_cmp || got.right_cmp !== want.right_cmp ||
                        got.pins !== want.pins || got.stopped !== want.stopped)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("mismatch at %0t: expected L=%0d R=%0d pins=%h stopped=%0d",
                                     $realtime, want.left_cmp, want.right_cmp, want.pins,
                                     want.stopped);
                            $display("    got L=%0d R=%0d pins=%h stopped=%0d",
                                     got.left_cmp, got.right_cmp, got.pins, got.stopped);
                        end
                    end
                end
            end

            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_PERIOD: period_q = cfg_data;
                    CFG_ACCEL:  accel_q  = cfg_data[STEP_W-1:0];
                    CFG_DECEL:  decel_q  = cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
                pending_drive_q.push_back(advance_drive(
                    motor_cmd_t'{op, motor_sel, duty_percent, direction, immediate}));

            // Watchdog: end the run when nothing moves for too long
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Result side: drop out_ready at random while idling is on
    always @(posedge clk)
    begin
        if (sink_hold > 0)
        begin
            out_ready <= 1'b0;
            sink_hold = sink_hold - 1;
        end
        else if (idle_en && $urandom_range(0, 5) == 0)
        begin
            out_ready <= 1'b0;
            sink_hold = $urandom_range(0, 2);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Send one command beat; valid is left high so the next beat can follow
    task automatic send_cmd(input motor_cmd_t c);
        if (idle_en && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        op           <= c.op;
        motor_sel    <= c.sel;
        duty_percent <= c.duty;
        direction    <= c.dir;
        immediate    <= c.imm;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic ramp_burst(input int count);
        int i;
        for (i = 0; i < count; i++)
            send_cmd(motor_cmd_t'{OP_TICK, SEL_LEFT, 7'd0, DIR_FWD, 1'b0});
    endtask

    // Drop valid and wait until every expected beat is back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_drive_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    // Write all three registers; only call while the unit is idle
    task automatic write_config(input logic [PERIOD_W-1:0] period_val,
                                input logic [STEP_W-1:0] accel_val,
                                input logic [STEP_W-1:0] decel_val);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_PERIOD;
        cfg_data  <= period_val;
        @(posedge clk);
        cfg_index <= CFG_ACCEL;
        cfg_data  <= PERIOD_W'(accel_val);
        @(posedge clk);
        cfg_index <= CFG_DECEL;
        cfg_data  <= PERIOD_W'(decel_val);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly well-formed commands and ticks, with some arbitrary noise
    function automatic motor_cmd_t random_cmd();
        motor_cmd_t  c;
        int unsigned pick;
        c.sel  = 2'($urandom_range(0, 2));
        c.dir  = ($urandom_range(0, 9) == 0) ? DIR_NONE : 2'($urandom_range(0, 1));
        c.duty = DUTY_W'($urandom_range(0, 100));
        c.imm  = ($urandom_range(0, 3) == 0);
        pick   = $urandom_range(0, 99);
        if (pick < 50)
            c.op = OP_TICK;
        else if (pick < 72)
            c.op = OP_SET_MOTOR;
        else if (pick < 78)
            c.op = OP_PIVOT_RIGHT;
        else if (pick < 84)
            c.op = OP_PIVOT_LEFT;
        else if (pick < 89)
            c.op = OP_STOP;
        else if (pick < 94)
            c.op = OP_ARM_NOTICE;
        else
        begin
            c.op   = 3'($urandom_range(0, 7));
            c.sel  = 2'($urandom_range(0, 3));
            c.duty = DUTY_W'($urandom_range(0, 127));
            c.dir  = 2'($urandom_range(0, 3));
            c.imm  = 1'($urandom_range(0, 1));
        end
        return c;
    endfunction

    // Every opcode, select and direction at reset configuration
    task automatic test_command_decode();
        send_cmd(motor_cmd_t'{OP_TICK,        SEL_LEFT,  7'd0,   DIR_FWD,  1'b0});
        send_cmd(motor_cmd_t'{OP_ARM_NOTICE,  SEL_LEFT,  7'd0,   DIR_FWD,  1'b0});
        send_cmd(motor_cmd_t'{OP_TICK,        SEL_LEFT,  7'd0,   DIR_FWD,  1'b0});
        send_cmd(motor_cmd_t'{OP_SET_MOTOR,   SEL_LEFT,  7'd100, DIR_FWD,  1'b0});
        send_cmd(motor_cmd_t'{OP_SET_MOTOR,   SEL_RIGHT, 7'd127, DIR_BACK, 1'b1});
        send_cmd(motor_cmd_t'{OP_SET_MOTOR,   SEL_BOTH,  7'd0,   DIR_FWD,  1'b0});
        send_cmd(motor_cmd_t'{OP_SET_MOTOR,   SEL_BOTH,  7'd55,  DIR_BACK, 1'b1});
        send_cmd(motor_cmd_t'{OP_SET_MOTOR,   SEL_LEFT,  7'd30,  DIR_NONE, 1'b0});
        send_cmd(motor_cmd_t'{OP_SET_MOTOR,   SEL_RIGHT, 7'd30,  DIR_NONE, 1'b1});
        send_cmd(motor_cmd_t'{OP_SET_MOTOR,   SEL_LEFT,  7'd70,  DIR_BAD,  1'b1});
        send_cmd(motor_cmd_t'{OP_SET_MOTOR,   SEL_RIGHT, 7'd70,  DIR_BAD,  1'b0});
        send_cmd(motor_cmd_t'{OP_SET_MOTOR,   SEL_BOTH,  7'd90,  DIR_FWD,  1'b1});
        send_cmd(motor_cmd_t'{OP_SET_MOTOR,   SEL_BOTH,  7'd90,  DIR_NONE, 1'b1});
        send_cmd(motor_cmd_t'{OP_SET_MOTOR,   SEL_BOTH,  7'd90,  DIR_BAD,  1'b0});
        send_cmd(motor_cmd_t'{OP_SET_MOTOR,   SEL_SPARE, 7'd80,  DIR_FWD,  1'b1});
        send_cmd(motor_cmd_t'{OP_PIVOT_RIGHT, SEL_SPARE, 7'd101, DIR_BAD,  1'b0});
        send_cmd(motor_cmd_t'{OP_TICK,        SEL_LEFT,  7'd0,   DIR_FWD,  1'b0});
        send_cmd(motor_cmd_t'{OP_PIVOT_LEFT,  SEL_LEFT,  7'd1,   DIR_NONE, 1'b1});
        send_cmd(motor_cmd_t'{OP_STOP,        SEL_BOTH,  7'd100, DIR_BACK, 1'b1});
        send_cmd(motor_cmd_t'{OP_TICK,        SEL_LEFT,  7'd0,   DIR_FWD,  1'b0});
        send_cmd(motor_cmd_t'{OP_SPARE_6,     SEL_SPARE, 7'd127, DIR_BAD,  1'b1});
        send_cmd(motor_cmd_t'{OP_SPARE_7,     SEL_SPARE, 7'd127, DIR_BAD,  1'b1});
        drain_results();
    endtask

    // Ramp up, stop, and see the armed notice fire once at zero
    task automatic test_stop_notice();
        write_config(16'd40, 8'd7, 8'd9);
        send_cmd(motor_cmd_t'{OP_SET_MOTOR,  SEL_BOTH, 7'd100, DIR_FWD, 1'b0});
        ramp_burst(7);
        send_cmd(motor_cmd_t'{OP_ARM_NOTICE, SEL_LEFT, 7'd0,   DIR_FWD, 1'b0});
        send_cmd(motor_cmd_t'{OP_STOP,       SEL_LEFT, 7'd0,   DIR_FWD, 1'b0});
        ramp_burst(7);
        send_cmd(motor_cmd_t'{OP_ARM_NOTICE, SEL_LEFT, 7'd0,   DIR_FWD, 1'b0});
        ramp_burst(2);
        drain_results();
    endtask

    // Extreme register settings, including a zero period and zero steps
    task automatic test_ramp_extremes();
        write_config(16'hFFFF, 8'hFF, 8'hFF);
        send_cmd(motor_cmd_t'{OP_SET_MOTOR,  SEL_BOTH,  7'd100, DIR_FWD,  1'b0});
        ramp_burst(6);
        send_cmd(motor_cmd_t'{OP_PIVOT_LEFT, SEL_LEFT,  7'd0,   DIR_FWD,  1'b0});
        ramp_burst(3);
        drain_results();

        // compares now sit above the new period and must snap
        write_config(16'd1, 8'd0, 8'd0);
        send_cmd(motor_cmd_t'{OP_SET_MOTOR,  SEL_LEFT,  7'd100, DIR_FWD,  1'b0});
        ramp_burst(3);
        send_cmd(motor_cmd_t'{OP_SET_MOTOR,  SEL_RIGHT, 7'd49,  DIR_BACK, 1'b0});
        ramp_burst(2);
        drain_results();

        write_config(16'd0, 8'd13, 8'd200);
        send_cmd(motor_cmd_t'{OP_SET_MOTOR,   SEL_BOTH, 7'd100, DIR_BACK, 1'b0});
        ramp_burst(2);
        send_cmd(motor_cmd_t'{OP_PIVOT_RIGHT, SEL_LEFT, 7'd77,  DIR_FWD,  1'b1});
        ramp_burst(1);
        drain_results();

        write_config(16'd100, 8'd1, 8'd1);
        send_cmd(motor_cmd_t'{OP_SET_MOTOR, SEL_BOTH, 7'd3, DIR_FWD, 1'b0});
        ramp_burst(4);
        drain_results();
    endtask

    // Random traffic over several random register settings
    task automatic test_random_traffic();
        int                  phase;
        int                  n;
        logic [PERIOD_W-1:0] period_val;
        for (phase = 0; phase < 5; phase++)
        begin
            period_val = ($urandom_range(0, 3) == 0) ? PERIOD_W'($urandom_range(1, 65535))
                                                     : PERIOD_W'($urandom_range(1, 400));
            write_config(period_val, STEP_W'($urandom_range(0, 255)),
                         STEP_W'($urandom_range(0, 255)));
            for (n = 0; n < 200; n++)
            begin
                if (n % 50 == 0)
                    idle_en = ($urandom_range(0, 3) != 0);
                send_cmd(random_cmd());
            end
            drain_results();
        end
    endtask

    // Closing stretch at full rate on both sides
    task automatic test_steady_flow();
        int n;
        idle_en = 1'b0;
        write_config(PERIOD_RESET, ACCEL_RESET, DECEL_RESET);
        for (n = 0; n < 200; n++)
            send_cmd(random_cmd());
        drain_results();
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= CFG_PERIOD;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        op           <= OP_TICK;
        motor_sel    <= SEL_LEFT;
        duty_percent <= '0;
        direction    <= DIR_FWD;
        immediate    <= 1'b0;
        out_ready    <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_command_decode();
        test_stop_notice();
        test_ramp_extremes();
        test_random_traffic();
        test_steady_flow();

        if (mismatch_count == 0 && pending_drive_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
